### hw/rtl/pse_pkg.sv
// printable string extractor package: constants, cell control struct, printable test
// no dependencies
package pse_pkg;

  localparam int MaxMinLen     = 63;
  localparam int OffsetBits    = 32;
  localparam int CountW        = $clog2(MaxMinLen + 1);
  localparam int LenW          = 6;
  localparam int ByteW         = 8;
  localparam int OutOffW       = 32;
  localparam logic [LenW-1:0]  DefaultMinLen = LenW'(4);
  localparam logic [ByteW-1:0] TabChar       = 8'h09;
  localparam logic [ByteW-1:0] PrintLo       = 8'h20;
  localparam logic [ByteW-1:0] PrintHi       = 8'h7e;

  typedef struct packed {
    logic capture;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic is_printable(input logic [ByteW-1:0] b);
    return ((b >= PrintLo) && (b <= PrintHi)) || (b == TabChar);
  endfunction

endpackage

### hw/rtl/pse_if.sv
// channel interfaces for the printable string extractor
// depends on pse_pkg
interface pse_in_if;
  logic                       valid;
  logic                       ready;
  logic [pse_pkg::ByteW-1:0]  in_byte;
  logic                       end_of_stream;
  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface pse_out_if;
  logic                         valid;
  logic                         ready;
  logic [pse_pkg::ByteW-1:0]    out_byte;
  logic [pse_pkg::OutOffW-1:0]  string_offset;
  logic                         is_end;
  logic                         last;
  modport source (output valid, output out_byte, output string_offset, output is_end,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input string_offset, input is_end,
                  input last, output ready);
endinterface

interface pse_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [pse_pkg::LenW-1:0]  min_length;
  modport source (output valid, output min_length, input ready);
  modport sink   (input valid, input min_length, output ready);
endinterface

### hw/rtl/pse_cell.sv
// one cell of the run buffer chain: holds one byte and its fill mark
// depends on pse_pkg
module pse_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  pse_pkg::cell_ctrl_t        ctrl,
  input  logic [pse_pkg::ByteW-1:0]  new_byte,
  input  logic                       low_occ,
  input  logic                       up_occ,
  input  logic [pse_pkg::ByteW-1:0]  up_byte,
  output logic                       occ,
  output logic [pse_pkg::ByteW-1:0]  data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.clear) begin
      occ <= 1'b0;
    end else if (ctrl.shift) begin
      occ <= up_occ;
    end else if (ctrl.capture && !occ && low_occ) begin
      occ <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= up_byte;
    end else if (ctrl.capture && !occ && low_occ) begin
      data <= new_byte;
    end
  end

endmodule

### hw/rtl/printable_string_extractor.sv
// printable string extractor top: control, offset counters, output register, cell row
// depends on pse_pkg, pse_if, pse_cell
// each result is registered in the output register; results follow one per cycle while strings.ready holds
// input is not ready while the results of an accepted byte are still pending
// the held run leaves the cell row one byte a cycle from cell 0 while the output is not stalled
// reset: synchronous, clears counters, fill marks and output valid; min_length returns to 4
module printable_string_extractor (
  input  logic            clk,
  input  logic            rst,
  pse_in_if.sink          bytes,
  pse_out_if.source       strings,
  pse_cfg_if.sink         cfg
);

  localparam int N = pse_pkg::MaxMinLen;

  logic [pse_pkg::LenW-1:0]       min_length;
  logic [pse_pkg::CountW-1:0]     run_count;
  logic [pse_pkg::OffsetBits-1:0] byte_offset;
  logic [pse_pkg::OffsetBits-1:0] run_start;
  logic                           in_string;
  logic [pse_pkg::CountW-1:0]     emit_cnt;
  logic                           direct_pend;
  logic [pse_pkg::ByteW-1:0]      direct_byte;
  logic                           end_pend;

  logic                           out_valid;
  logic [pse_pkg::ByteW-1:0]      out_byte;
  logic [pse_pkg::OutOffW-1:0]    out_off;
  logic                           out_end;
  logic                           out_last;

  logic [N-1:0]                   cell_occ;
  logic [pse_pkg::ByteW-1:0]      cell_data [N];
  pse_pkg::cell_ctrl_t            ctrl;

  logic                           accept;
  logic                           busy;
  logic                           step;
  logic                           printable;
  logic                           reach;
  logic [pse_pkg::CountW-1:0]     cnt1;
  logic [pse_pkg::CountW-1:0]     eff_min;

  always_comb begin
    if (min_length == '0) begin
      eff_min = pse_pkg::CountW'(1);
    end else if (pse_pkg::CountW'(min_length) > pse_pkg::CountW'(N)) begin
      eff_min = pse_pkg::CountW'(N);
    end else begin
      eff_min = pse_pkg::CountW'(min_length);
    end
  end

  assign busy      = (emit_cnt != '0) || direct_pend || end_pend;
  assign bytes.ready = !busy;
  assign accept    = bytes.valid && !busy;
  assign printable = pse_pkg::is_printable(bytes.in_byte);
  assign cnt1      = run_count + 1'b1;
  assign reach     = cnt1 >= eff_min;
  assign step      = busy && (!out_valid || strings.ready);
  assign cfg.ready = 1'b1;

  assign ctrl.capture = accept && printable && !in_string;
  assign ctrl.shift   = step && (emit_cnt != '0);
  assign ctrl.clear   = accept && (!printable ||
                        (bytes.end_of_stream && !(printable && !in_string && reach)));

  // cell row, fill grows from cell 0 and drains toward it
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                      low_occ;
    logic                      up_occ;
    logic [pse_pkg::ByteW-1:0] up_byte;
    if (i == 0) begin : g_head
      assign low_occ = 1'b1;
    end else begin : g_body
      assign low_occ = cell_occ[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign up_occ  = 1'b0;
      assign up_byte = '0;
    end else begin : g_next
      assign up_occ  = cell_occ[i+1];
      assign up_byte = cell_data[i+1];
    end
    pse_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .new_byte (bytes.in_byte),
      .low_occ  (low_occ),
      .up_occ   (up_occ),
      .up_byte  (up_byte),
      .occ      (cell_occ[i]),
      .data     (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= pse_pkg::DefaultMinLen;
    end else if (cfg.valid) begin
      min_length <= cfg.min_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count   <= '0;
      byte_offset <= '0;
      run_start   <= '0;
      in_string   <= 1'b0;
      emit_cnt    <= '0;
      direct_pend <= 1'b0;
      end_pend    <= 1'b0;
    end else if (accept) begin
      byte_offset <= bytes.end_of_stream ? '0 : byte_offset + 1'b1;
      if (printable) begin
        if (in_string) begin
          direct_pend <= 1'b1;
          end_pend    <= bytes.end_of_stream;
          in_string   <= !bytes.end_of_stream;
        end else begin
          if (run_count == '0) begin
            run_start <= byte_offset;
          end
          if (reach) begin
            emit_cnt  <= cnt1;
            run_count <= '0;
            in_string <= !bytes.end_of_stream;
            end_pend  <= bytes.end_of_stream;
          end else begin
            run_count <= bytes.end_of_stream ? '0 : cnt1;
          end
        end
      end else begin
        end_pend  <= in_string;
        in_string <= 1'b0;
        run_count <= '0;
      end
    end else if (step) begin
      if (emit_cnt != '0) begin
        emit_cnt <= emit_cnt - 1'b1;
      end else if (direct_pend) begin
        direct_pend <= 1'b0;
      end else begin
        end_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      direct_byte <= bytes.in_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (strings.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_off <= run_start[pse_pkg::OutOffW-1:0];
      if (emit_cnt != '0) begin
        out_byte <= cell_data[0];
        out_end  <= 1'b0;
        out_last <= (emit_cnt == pse_pkg::CountW'(1)) && !end_pend;
      end else if (direct_pend) begin
        out_byte <= direct_byte;
        out_end  <= 1'b0;
        out_last <= !end_pend;
      end else begin
        out_byte <= '0;
        out_end  <= 1'b1;
        out_last <= 1'b1;
      end
    end
  end

  assign strings.valid         = out_valid;
  assign strings.out_byte      = out_byte;
  assign strings.string_offset = out_off;
  assign strings.is_end        = out_end;
  assign strings.last          = out_last;

  a_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.capture && ctrl.shift))
    else $error("capture and shift in the same cycle");

  a_head_full: assert property (@(posedge clk) disable iff (rst)
    (emit_cnt != '0) |-> cell_occ[0])
    else $error("draining with an empty head cell");

  a_drop_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && !printable) |=> (cell_occ == '0))
    else $error("cell row not cleared after a non-printable byte");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(cell_occ) == int'(run_count)))
    else $error("fill marks disagree with run count");

endmodule
